// ===== hw/rtl/opsc_pkg.sv =====
// Shared constants, controller command codes and control/status types for the sieve counter.
package opsc_pkg;

    localparam int MAX_BOUND_BITS_DEF = 20;
    localparam int BOUND_W            = 21;
    localparam int COUNT_W            = 21;
    // working width for p, 3p and t + 2p with a 21-bit bound
    localparam int NUM_W              = 23;
    localparam int TDATA_W            = ((BOUND_W + 7) / 8) * 8;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;
    localparam t_op OP_CLEAR     = 4'd2;
    localparam t_op OP_SINIT     = 4'd3;
    localparam t_op OP_SREAD     = 4'd4;
    localparam t_op OP_SNEXT     = 4'd5;
    localparam t_op OP_SSTART    = 4'd6;
    localparam t_op OP_MARK      = 4'd7;
    localparam t_op OP_MARK_LAST = 4'd8;
    localparam t_op OP_CINIT     = 4'd9;
    localparam t_op OP_COUNT     = 4'd10;
    localparam t_op OP_EMIT      = 4'd11;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic p_lt_bound;
        logic bit_set;
        logic t3_ge_bound;
        logic tnext_ge_bound;
        logic cnt_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/opsc_bitmap.sv =====
// Single-port bit memory, one bit per odd number, registered read data.
module opsc_bitmap #(
    parameter int ADDR_W = opsc_pkg::MAX_BOUND_BITS_DEF - 1
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_we,
    input  logic              i_wdata,
    output logic              o_rdata
);

    localparam longint DEPTH = longint'(1) << ADDR_W;

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/opsc_datapath.sv =====
// Sieve datapath: bound, pointers, tally, bitmap port and output register.
module opsc_datapath #(
    parameter int MAX_BOUND_BITS = opsc_pkg::MAX_BOUND_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  opsc_pkg::t_cmd                i_cmd,
    output opsc_pkg::t_sts                o_sts,
    input  logic [opsc_pkg::BOUND_W-1:0]  i_bound,
    output logic                          o_out_valid,
    output logic [opsc_pkg::COUNT_W-1:0]  o_out_data,
    input  logic                          i_out_ready
);

    localparam int ADDR_W = MAX_BOUND_BITS - 1;
    localparam int NW     = opsc_pkg::NUM_W;
    localparam int BW     = opsc_pkg::BOUND_W;
    localparam int CW     = opsc_pkg::COUNT_W;
    localparam logic [32:0] MaxBound = 33'd1 << MAX_BOUND_BITS;

    logic [BW-1:0] r_bound;
    logic [NW-1:0] r_p, n_p;
    logic [NW-1:0] r_t, n_t;
    logic [CW-1:0] r_count, n_count;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_data;

    logic [NW-1:0]     bound_ext;
    logic [NW-1:0]     p2;
    logic [NW-1:0]     p3;
    logic [NW-1:0]     tnext;
    logic [BW-1:0]     bound_clamped;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_wdata;
    logic              mem_rdata;

    // map index of an odd number: n >> 1
    function automatic logic [ADDR_W-1:0] f_idx(input logic [NW-1:0] n);
        logic [NW+ADDR_W-1:0] ext;
        ext = {{ADDR_W{1'b0}}, n} >> 1;
        return ext[ADDR_W-1:0];
    endfunction

    assign bound_ext = {{(NW-BW){1'b0}}, r_bound};
    assign p2        = r_p << 1;
    assign p3        = r_p + p2;
    assign tnext     = r_t + p2;

    always_comb begin
        if ({12'd0, i_bound} > MaxBound) begin
            bound_clamped = MaxBound[BW-1:0];
        end else begin
            bound_clamped = i_bound;
        end
    end

    assign o_sts.p_lt_bound     = (r_p < bound_ext);
    assign o_sts.bit_set        = mem_rdata;
    assign o_sts.t3_ge_bound    = (p3 >= bound_ext);
    assign o_sts.tnext_ge_bound = (tnext >= bound_ext);
    assign o_sts.cnt_done       = !(r_p < bound_ext) && !r_pend;
    assign o_sts.out_free       = !r_out_valid || i_out_ready;

    always_comb begin
        n_p         = r_p;
        n_t         = r_t;
        n_count     = r_count;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        mem_addr    = f_idx(r_p);
        mem_we      = 1'b0;
        mem_wdata   = 1'b1;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (i_cmd.op)
            opsc_pkg::OP_LOAD: begin
                n_p = NW'(1);
            end
            opsc_pkg::OP_CLEAR: begin
                // clear pass; number one is marked composite on the way
                mem_we    = 1'b1;
                mem_wdata = (r_p == NW'(1));
                n_p       = r_p + NW'(2);
            end
            opsc_pkg::OP_SINIT: begin
                n_p = NW'(3);
            end
            opsc_pkg::OP_SREAD: begin
                mem_addr = f_idx(r_p);
            end
            opsc_pkg::OP_SNEXT: begin
                n_p = r_p + NW'(2);
            end
            opsc_pkg::OP_SSTART: begin
                n_t = p3;
            end
            opsc_pkg::OP_MARK: begin
                mem_addr = f_idx(r_t);
                mem_we   = 1'b1;
                n_t      = tnext;
            end
            opsc_pkg::OP_MARK_LAST: begin
                mem_addr = f_idx(r_t);
                mem_we   = 1'b1;
                n_t      = tnext;
                n_p      = r_p + NW'(2);
            end
            opsc_pkg::OP_CINIT: begin
                n_p     = NW'(3);
                n_pend  = 1'b0;
                n_count = CW'(1);
            end
            opsc_pkg::OP_COUNT: begin
                // read of the odd number issued last cycle lands now
                if (r_pend && !mem_rdata) begin
                    n_count = r_count + CW'(1);
                end
                mem_addr = f_idx(r_p);
                n_pend   = (r_p < bound_ext);
                if (r_p < bound_ext) begin
                    n_p = r_p + NW'(2);
                end
            end
            opsc_pkg::OP_EMIT: begin
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_t     <= n_t;
        r_count <= n_count;
        if (i_cmd.op == opsc_pkg::OP_LOAD) begin
            r_bound <= bound_clamped;
        end
        if (i_cmd.op == opsc_pkg::OP_EMIT) begin
            r_out_data <= r_count;
        end
    end

    opsc_bitmap #(
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_addr  (mem_addr),
        .i_we    (mem_we),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/opsc_ctrl.sv =====
// Sequencer for clear, sieve, mark and count phases.
module opsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  opsc_pkg::t_sts i_sts,
    output opsc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SRD   = 3'd2;
    localparam logic [2:0] S_SCHK  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_CNT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = opsc_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = opsc_pkg::OP_LOAD;
                    n_state  = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_sts.p_lt_bound) begin
                    o_cmd.op = opsc_pkg::OP_CLEAR;
                end else begin
                    o_cmd.op = opsc_pkg::OP_SINIT;
                    n_state  = S_SRD;
                end
            end
            S_SRD: begin
                if (i_sts.p_lt_bound) begin
                    o_cmd.op = opsc_pkg::OP_SREAD;
                    n_state  = S_SCHK;
                end else begin
                    o_cmd.op = opsc_pkg::OP_CINIT;
                    n_state  = S_CNT;
                end
            end
            S_SCHK: begin
                if (i_sts.bit_set) begin
                    o_cmd.op = opsc_pkg::OP_SNEXT;
                    n_state  = S_SRD;
                end else if (i_sts.t3_ge_bound) begin
                    // first prime with 3p past the bound ends the sieve
                    o_cmd.op = opsc_pkg::OP_CINIT;
                    n_state  = S_CNT;
                end else begin
                    o_cmd.op = opsc_pkg::OP_SSTART;
                    n_state  = S_MARK;
                end
            end
            S_MARK: begin
                if (i_sts.tnext_ge_bound) begin
                    o_cmd.op = opsc_pkg::OP_MARK_LAST;
                    n_state  = S_SRD;
                end else begin
                    o_cmd.op = opsc_pkg::OP_MARK;
                end
            end
            S_CNT: begin
                o_cmd.op = opsc_pkg::OP_COUNT;
                if (i_sts.cnt_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = opsc_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/odd_prime_sieve_counter_unit.sv =====
// Top level of the odd-only sieve prime counter.
// Usage:
//   One beat on s_axis carries an exclusive upper bound; the block answers with
//   one beat on m_axis holding the number of primes below that bound, two
//   always counted, so bounds up to two give one. Bounds above 2^MAX_BOUND_BITS
//   are clamped to it. Each request runs four phases over a single-port bitmap
//   with one bit per odd number, at most one memory access per cycle: a clear
//   pass over floor(B/2) entries, a sieve read of the odd candidates, a mark
//   pass over the odd multiples of each prime found from 3p on, then a count
//   pass of about B/2 reads. One request is worked at a time.
//   s_axis_tready is high only while the block is idle. The result sits in
//   an output register, so a new request is taken while the previous result
//   still waits on a stalled m_axis; a finished run holds until that register
//   is free. Synchronous active-low reset returns the sequencer to idle and
//   drops m_axis_tvalid; the bitmap is not reset, every run clears it first.
module odd_prime_sieve_counter_unit #(
    parameter int MAX_BOUND_BITS = opsc_pkg::MAX_BOUND_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [20:0] upper_bound, [23:21] zero
    input  logic [opsc_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [20:0] prime_count, [23:21] zero
    output logic [opsc_pkg::TDATA_W-1:0]  m_axis_tdata
);

    opsc_pkg::t_cmd                 cmd;
    opsc_pkg::t_sts                 sts;
    logic [opsc_pkg::COUNT_W-1:0]   out_data;

    opsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    opsc_datapath #(
        .MAX_BOUND_BITS (MAX_BOUND_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_bound     (s_axis_tdata[opsc_pkg::BOUND_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(opsc_pkg::TDATA_W - opsc_pkg::COUNT_W){1'b0}}, out_data};

endmodule

// ===== sim/testbench.sv =====
// Self-checking stream testbench for the odd-only sieve prime counter.
module testbench;

    localparam int TDATA_W   = opsc_pkg::TDATA_W;
    localparam int BOUND_W   = opsc_pkg::BOUND_W;
    localparam int COUNT_W   = opsc_pkg::COUNT_W;
    localparam int MAX_BOUND = 1 << opsc_pkg::MAX_BOUND_BITS_DEF;
    localparam int MAP_DEPTH = 1 << (opsc_pkg::MAX_BOUND_BITS_DEF - 1);

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    // predictor state: one flag per odd number, set means composite
    bit                 odd_composite [MAP_DEPTH];
    logic [BOUND_W-1:0] last_sieve_prime = '0;
    logic [BOUND_W-1:0] last_mark_pos = '0;
    logic [COUNT_W-1:0] last_prime_count = '0;

    logic [COUNT_W-1:0] expected_counts [$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    odd_prime_sieve_counter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [20:0] upper_bound, [23:21] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [20:0] prime_count, [23:21] zero
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sieves odd numbers below the clamped bound and returns the prime count, two included.
    function automatic logic [COUNT_W-1:0] count_primes_below(logic [BOUND_W-1:0] bound);
        int lim;
        int p;
        int t;
        int stride;
        int tally;
        lim = (bound > MAX_BOUND) ? MAX_BOUND : int'(bound);
        for (int i = 0; i < (lim + 1) / 2 && i < MAP_DEPTH; i++)
            odd_composite[i] = 1'b0;
        odd_composite[0] = 1'b1;
        t = 0;
        for (p = 3; p < lim; p += 2) begin
            if (!odd_composite[p >> 1]) begin
                stride = 2 * p;
                t = p + stride;
                if (t >= lim)
                    break;
                while (t < lim) begin
                    odd_composite[t >> 1] = 1'b1;
                    t += stride;
                end
            end
        end
        last_sieve_prime = p[BOUND_W-1:0];
        last_mark_pos = t[BOUND_W-1:0];
        tally = 1;
        for (p = 3; p < lim; p += 2)
            if (!odd_composite[p >> 1])
                tally++;
        last_prime_count = tally[COUNT_W-1:0];
        return last_prime_count;
    endfunction

    // tvalid stays high across back-to-back beats; it only drops inside an idle gap
    task automatic send_bound(input logic [BOUND_W-1:0] bound);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W - BOUND_W){1'b0}}, bound};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_counts.push_back(count_primes_below(bound));
    endtask

    // result side: random back-pressure, compare each beat with the oldest expected count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_counts.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected result beat: prime_count=%0d",
                                 m_axis_tdata[COUNT_W-1:0]);
                    error_count++;
                end else if (m_axis_tdata[COUNT_W-1:0] != expected_counts[0]) begin
                    if (error_count < 10)
                        $display("prime_count mismatch: expected %0d, got %0d",
                                 expected_counts[0], m_axis_tdata[COUNT_W-1:0]);
                    error_count++;
                    void'(expected_counts.pop_front());
                end else begin
                    void'(expected_counts.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // tiny bounds, bounds just past odd squares and primes, a few mid sizes
    task automatic test_edge_bounds();
        logic [BOUND_W-1:0] bounds [$];
        bounds = '{21'd0, 21'd1, 21'd2, 21'd3, 21'd4, 21'd5, 21'd6, 21'd7, 21'd8,
                   21'd9, 21'd10, 21'd11, 21'd12, 21'd25, 21'd26, 21'd27, 21'd49,
                   21'd50, 21'd121, 21'd122, 21'd1000, 21'd4096, 21'd4097};
        foreach (bounds[i])
            send_bound(bounds[i]);
    endtask

    // mostly small bounds so the run stays short, a few reaching into the upper bits
    task automatic test_random_bounds(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_bound(BOUND_W'($urandom_range(300)));
            else if (pick < 90)
                send_bound(BOUND_W'($urandom_range(4095)));
            else if (pick < 97)
                send_bound(BOUND_W'($urandom_range(32767)));
            else
                send_bound(BOUND_W'($urandom_range(131071)));
        end
    endtask

    // the exact maximum and the all-ones bound, which clamps to it
    task automatic test_clamped_bounds();
        send_bound(BOUND_W'(MAX_BOUND));
        send_bound({BOUND_W{1'b1}});
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 32;
        recv_idle_pct = 50;
        test_edge_bounds();
        test_random_bounds(26);

        send_idle_pct = 50;
        recv_idle_pct = 32;
        test_random_bounds(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_bounds(25);
        test_clamped_bounds();
        s_axis_tvalid <= 1'b0;

        while (expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
